@@ rtl/btpc_pkg.sv @@
// Package: widths, constants, register codes and shared types of the pulse counter.
`timescale 1ns / 1ps
package btpc_pkg;

  localparam int SAMPLE_W    = 10;
  localparam int GAIN_W      = 10;
  localparam int PERIOD_W    = 8;
  localparam int COUNT_W     = 16;

  localparam int SHORT_DEPTH = 3;
  localparam int SPOS_W      = (SHORT_DEPTH > 1) ? $clog2(SHORT_DEPTH) : 1;
  localparam int SSUM_W      = SAMPLE_W + SPOS_W;
  // floor(x / SHORT_DEPTH) == (x * SHORT_RECIP) >> RECIP_SHIFT for every x below 2**SSUM_W
  localparam int RECIP_SHIFT = SSUM_W + SPOS_W;
  localparam int SHORT_RECIP = (2 ** RECIP_SHIFT + SHORT_DEPTH - 1) / SHORT_DEPTH;
  localparam int PROD_W      = SSUM_W + RECIP_SHIFT;

  // baseline ring depth is a power of two, so its average is a shift
  localparam int BASE_DEPTH  = 256;
  localparam int BPOS_W      = $clog2(BASE_DEPTH);
  localparam int BSUM_W      = SAMPLE_W + BPOS_W;
  localparam int FILL_W      = BPOS_W + 1;

  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [GAIN_W-1:0]   GAIN_RESET   = GAIN_W'(154);
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(10);

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [BPOS_W-1:0]   bpos_t;

  typedef enum logic {
    REG_GAIN   = 1'b0,
    REG_PERIOD = 1'b1
  } btpc_reg_t;

  // control from the sample pipeline to the baseline ring
  typedef struct packed {
    logic    rd_en;     // fetch the oldest entry for a later replacement
    bpos_t   rd_addr;
    logic    wr_en;     // write sample into ring and fold it into the sum
    bpos_t   wr_addr;
    sample_t wr_data;
    logic    sub_old;   // ring full: drop the fetched entry from the sum
    logic    load_avg;  // refresh the baseline average
  } btpc_base_ctl_t;

endpackage

@@ rtl/btpc_baseline.sv @@
// Baseline ring memory with running sum and truncated average.
`timescale 1ns / 1ps
module btpc_baseline (
  input  logic                    clk,
  input  logic                    rst_n,
  input  btpc_pkg::btpc_base_ctl_t ctl,
  output btpc_pkg::sample_t       avg_nxt
);
  import btpc_pkg::*;

  sample_t             ring_mem [BASE_DEPTH];
  sample_t             rd_data_r;
  logic [BSUM_W-1:0]   base_sum_r;
  logic [BSUM_W-1:0]   base_sum_nxt;
  sample_t             base_avg_r;
  sample_t             old_val;

  // read and write never hit the same entry in one cycle: the write
  // address trails the read address by one ring slot
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      ring_mem[ctl.wr_addr] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= ring_mem[ctl.rd_addr];
    end
  end

  always_comb begin
    old_val      = ctl.sub_old ? rd_data_r : '0;
    base_sum_nxt = base_sum_r - BSUM_W'(old_val) + BSUM_W'(ctl.wr_data);
    avg_nxt      = ctl.load_avg ? base_sum_nxt[BSUM_W-1 -: SAMPLE_W] : base_avg_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_sum_r <= '0;
      base_avg_r <= '0;
    end else if (ctl.wr_en) begin
      base_sum_r <= base_sum_nxt;
      base_avg_r <= avg_nxt;
    end
  end

endmodule

@@ rtl/baseline_tracking_pulse_counter.sv @@
// Top level: sample pipeline, pulse detector, output register and APB registers.
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Payload
// in_       slave      in_tvalid/in_tready   tdata[9:0] sample
// out_      master     out_tvalid/out_tready tdata: short_average, baseline, pulse_active,
//                                            pulse_edge, pulse_count; tuser: calibrating
// cfg_      APB slave  psel/penable/pready   reg 0 gain_factor_q10, reg 4 decimation_period
//
// One sample per cycle sustained while the output is not stalled; out_tvalid rises after
// three register stages: memory fetch, sum update and divide, threshold compare into the
// output register.
// The figure is set by the baseline ring memory: one read and one write port per cycle.
// rst_n is synchronous; the baseline ring needs no clearing, it is filled by the first
// 256 samples before any entry is read back.
// A stalled output freezes the whole pipeline; in_tready drops only while out_tvalid
// is high and out_tready is low.
module baseline_tracking_pulse_counter (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [15:0]                          in_tdata,   // [9:0] sample
  // result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [39:0]                          out_tdata,  // [9:0] short_average,
                                                           // [19:10] baseline,
                                                           // [20] pulse_active,
                                                           // [21] pulse_edge,
                                                           // [37:22] pulse_count
  output logic                                 out_tuser,  // [0] calibrating
  // configuration
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [btpc_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [btpc_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [btpc_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                 cfg_pready
);
  import btpc_pkg::*;

  // ---------------- configuration registers ----------------
  logic [GAIN_W-1:0]   gain_r;
  logic [PERIOD_W-1:0] period_r;
  logic                cfg_wr;
  btpc_reg_t           cfg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_sel    = btpc_reg_t'(cfg_paddr[2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= GAIN_RESET;
      period_r <= PERIOD_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_GAIN:   gain_r   <= cfg_pwdata[GAIN_W-1:0];
        REG_PERIOD: period_r <= cfg_pwdata[PERIOD_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_GAIN:   cfg_prdata = CFG_DATA_W'(gain_r);
      REG_PERIOD: cfg_prdata = CFG_DATA_W'(period_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // ---------------- pipeline advance ----------------
  logic out_valid_r;
  logic advance;
  logic accept;

  assign advance   = !out_valid_r || out_tready;   // whole pipeline moves together
  assign in_tready = advance;
  assign accept    = in_tvalid && in_tready;

  // ---------------- stage 0: ring pointers, short sum ----------------
  sample_t             sample_in;
  logic [FILL_W-1:0]   fill_r;
  logic [PERIOD_W-1:0] decim_r;
  logic [PERIOD_W-1:0] period_eff;
  logic                calib0;
  logic                last0;
  logic                upd0;
  bpos_t               base_pos_r;
  bpos_t               base_pos_inc;
  logic [SPOS_W-1:0]   short_pos_r;
  logic [SPOS_W-1:0]   short_pos_inc;
  sample_t             short_ring_r [SHORT_DEPTH];
  logic [SSUM_W-1:0]   short_sum_r;
  logic [SSUM_W-1:0]   short_sum_nxt;
  logic [PERIOD_W:0]   decim_inc;

  assign sample_in  = in_tdata[SAMPLE_W-1:0];
  assign calib0     = fill_r < FILL_W'(BASE_DEPTH);
  assign last0      = fill_r == FILL_W'(BASE_DEPTH - 1);
  assign upd0       = !calib0 && (decim_r == '0);
  assign period_eff = (period_r == '0) ? PERIOD_W'(1) : period_r;
  assign decim_inc  = {1'b0, decim_r} + (PERIOD_W + 1)'(1);

  always_comb begin
    base_pos_inc  = (base_pos_r == bpos_t'(BASE_DEPTH - 1)) ? '0 : base_pos_r + bpos_t'(1);
    short_pos_inc = (short_pos_r == SPOS_W'(SHORT_DEPTH - 1)) ? '0
                  : short_pos_r + SPOS_W'(1);
    short_sum_nxt = short_sum_r - SSUM_W'(short_ring_r[short_pos_r]) + SSUM_W'(sample_in);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      decim_r     <= '0;
      base_pos_r  <= '0;
      short_pos_r <= '0;
      short_sum_r <= '0;
      for (int i = 0; i < SHORT_DEPTH; i++) begin
        short_ring_r[i] <= '0;
      end
    end else if (accept) begin
      if (calib0) begin
        fill_r     <= fill_r + FILL_W'(1);
        base_pos_r <= base_pos_inc;
      end else begin
        short_ring_r[short_pos_r] <= sample_in;
        short_sum_r               <= short_sum_nxt;
        short_pos_r               <= short_pos_inc;
        decim_r <= (decim_inc >= {1'b0, period_eff}) ? '0 : decim_inc[PERIOD_W-1:0];
        if (upd0) begin
          base_pos_r <= base_pos_inc;
        end
      end
    end
  end

  // stage 1 registers
  logic              s1_valid_r;
  logic              s1_calib_r;
  logic              s1_last_r;
  logic              s1_upd_r;
  bpos_t             s1_pos_r;
  sample_t           s1_sample_r;
  logic [SSUM_W-1:0] s1_ssum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_calib_r  <= calib0;
      s1_last_r   <= last0;
      s1_upd_r    <= upd0;
      s1_pos_r    <= base_pos_r;
      s1_sample_r <= sample_in;
      s1_ssum_r   <= short_sum_nxt;
    end
  end

  // ---------------- stage 1: baseline ring update, short divide ----------------
  btpc_base_ctl_t base_ctl;
  sample_t        base_avg_nxt;
  logic [PROD_W-1:0] short_prod;
  sample_t        savg1;
  logic           s1_write;

  assign s1_write = s1_valid_r && (s1_calib_r || s1_upd_r);

  always_comb begin
    base_ctl.rd_en    = accept && upd0;
    base_ctl.rd_addr  = base_pos_r;
    base_ctl.wr_en    = advance && s1_write;
    base_ctl.wr_addr  = s1_pos_r;
    base_ctl.wr_data  = s1_sample_r;
    base_ctl.sub_old  = !s1_calib_r;
    base_ctl.load_avg = s1_upd_r || s1_last_r;
  end

  btpc_baseline u_baseline (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (base_ctl),
    .avg_nxt (base_avg_nxt)
  );

  assign short_prod = PROD_W'(s1_ssum_r) * PROD_W'(SHORT_RECIP);
  assign savg1      = s1_calib_r ? '0 : short_prod[RECIP_SHIFT +: SAMPLE_W];

  // stage 2 registers
  logic    s2_valid_r;
  logic    s2_calib_r;
  sample_t s2_savg_r;
  sample_t s2_bavg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (advance) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_calib_r <= s1_calib_r;
      s2_savg_r  <= savg1;
      s2_bavg_r  <= base_avg_nxt;
    end
  end

  // ---------------- stage 2: threshold compare, edge count ----------------
  localparam int LHS_W = SAMPLE_W + GAIN_W + 1;
  logic [LHS_W-1:0]   thr_lhs;
  logic [LHS_W-1:0]   thr_rhs;
  logic               above;
  logic               pulse_r;
  logic [COUNT_W-1:0] pulses_r;
  logic               edge2;
  logic               active2;
  logic [COUNT_W-1:0] pulses_nxt;

  always_comb begin
    thr_lhs    = {1'b0, s2_savg_r, {GAIN_W{1'b0}}};
    thr_rhs    = LHS_W'(s2_bavg_r) * LHS_W'({1'b1, gain_r});
    above      = thr_lhs > thr_rhs;
    edge2      = !s2_calib_r && above && !pulse_r;
    active2    = !s2_calib_r && above;
    pulses_nxt = edge2 ? pulses_r + COUNT_W'(1) : pulses_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_r  <= 1'b0;
      pulses_r <= '0;
    end else if (advance && s2_valid_r && !s2_calib_r) begin
      pulse_r  <= above;
      pulses_r <= pulses_nxt;
    end
  end

  // ---------------- output register ----------------
  sample_t            out_savg_r;
  sample_t            out_bavg_r;
  logic               out_active_r;
  logic               out_edge_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_calib_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s2_valid_r) begin
      out_savg_r   <= s2_savg_r;
      out_bavg_r   <= s2_bavg_r;
      out_active_r <= active2;
      out_edge_r   <= edge2;
      out_count_r  <= pulses_nxt;
      out_calib_r  <= s2_calib_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_count_r, out_edge_r, out_active_r, out_bavg_r, out_savg_r};
  assign out_tuser  = out_calib_r;

endmodule

@@ rtl/btpc_checker.sv @@
// Port-level checker for the pulse counter, bound to the top level.
`timescale 1ns / 1ps
module btpc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tuser
);

  // nothing is offered on the cycle after reset
  a_reset_idle: assert property (@(posedge clk) !$past(rst_n) |-> !out_tvalid)
    else $error("out_tvalid high right after reset");

  // a result stalled downstream is held unchanged
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // input is blocked only by a stalled result
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("in_tready low while output free");

  // an edge is always an active pulse, and calibration shows no pulse
  a_edge: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tdata[21] || out_tdata[20]) && (!out_tuser || !out_tdata[20]))
    else $error("inconsistent pulse flags");

endmodule

bind baseline_tracking_pulse_counter btpc_checker u_btpc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
